// ===== rtl/kmp_stream_matcher_core_macros.svh =====
// Assertion helpers used by the matcher datapath.
`ifndef KMP_STREAM_MATCHER_CORE_MACROS_SVH
`define KMP_STREAM_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define KMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kmp_pkg.sv =====
package kmp_pkg;

    // Default pattern capacity
    localparam int KMP_MAX_PATTERN = 64;

    // Field widths
    localparam int KMP_CMD_W  = 2;
    localparam int KMP_BYTE_W = 8;
    localparam int KMP_POS_W  = 32;

    // Item command codes
    localparam logic [KMP_CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [KMP_CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [KMP_CMD_W-1:0] CMD_TEXT  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // item taken this cycle
        logic step;     // fall back one failure entry
        logic finish;   // walk ends, commit state and result
    } kmp_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_start;  // incoming item needs a table walk
        logic walk_done;   // current walk position hits or reached zero
        logic res_free;    // result slot can take an item this cycle
    } kmp_sts_t;

endpackage

// ===== rtl/kmp_item_if.sv =====
interface kmp_item_if import kmp_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [KMP_CMD_W-1:0]  cmd;
    logic [KMP_BYTE_W-1:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// ===== rtl/kmp_result_if.sv =====
interface kmp_result_if import kmp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [KMP_POS_W-1:0] match_start;
    logic                 status;

    modport source (output valid, output found, output match_start, output status,
                    input ready);
    modport sink   (input valid, input found, input match_start, input status,
                    output ready);
endinterface

// ===== rtl/kmp_ram.sv =====
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/kmp_ctrl.sv =====
module kmp_ctrl import kmp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  kmp_sts_t  sts,
    output kmp_ctl_t  ctl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg;
    logic state_next;

    // Take items only when idle and the result slot is free
    assign item_ready = (state_reg == ST_IDLE) && sts.res_free;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.accept = item_valid && item_ready;
                if (ctl.accept && sts.walk_start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // one table lookup per cycle until hit or zero
                if (sts.walk_done)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/kmp_dp.sv =====
`include "kmp_stream_matcher_core_macros.svh"

module kmp_dp import kmp_pkg::*; #(
    parameter int MAX_PATTERN = KMP_MAX_PATTERN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KMP_CMD_W-1:0]  item_cmd,
    input  logic [KMP_BYTE_W-1:0] item_byte,
    input  kmp_ctl_t              ctl,
    output kmp_sts_t              sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [KMP_POS_W-1:0]  match_start,
    output logic                  status
);

    localparam int IW = $clog2(MAX_PATTERN);
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(MAX_PATTERN);

    // Match state
    logic [LW-1:0]         len_reg, len_next;
    logic [IW-1:0]         bpl_reg, bpl_next;
    logic [IW-1:0]         tml_reg, tml_next;
    logic [KMP_POS_W-1:0]  pos_reg, pos_next;

    // Walk context
    logic                  is_text_reg;
    logic [KMP_BYTE_W-1:0] byte_reg;
    logic [IW-1:0]         k_reg;

    // Result skid and output stage
    logic                  res_valid_reg, res_valid_next;
    logic                  res_found_reg;
    logic [KMP_POS_W-1:0]  res_start_reg;
    logic                  res_status_reg;
    logic                  res_write;
    logic                  res_found_next;
    logic [KMP_POS_W-1:0]  res_start_next;
    logic                  res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg;
    logic [KMP_POS_W-1:0]  out_start_reg;
    logic                  out_status_reg;
    logic                  out_load;

    // Memory ports
    logic                  pat_we;
    logic [KMP_BYTE_W-1:0] pat_q;
    logic                  fail_we;
    logic [IW-1:0]         fail_waddr;
    logic [IW-1:0]         fail_wdata;
    logic [IW-1:0]         fail_raddr;
    logic [IW-1:0]         fail_q;
    logic [IW-1:0]         rd_k;

    // Decode and walk signals
    logic                  full;
    logic                  is_load;
    logic                  is_text;
    logic [IW-1:0]         start_k;
    logic                  hit;
    logic [LW-1:0]         k_final;
    logic                  text_hit;

    assign full    = (len_reg == LEN_FULL);
    assign is_load = (item_cmd == CMD_LOAD);
    assign is_text = (item_cmd == CMD_TEXT);
    assign start_k = is_text ? tml_reg : bpl_reg;

    assign hit      = (pat_q == byte_reg);
    assign k_final  = hit ? (LW'(k_reg) + LW'(1)) : '0;
    assign text_hit = (k_final == len_reg);

    // Read address: start of the walk, or the failure entry just read
    assign rd_k       = ctl.accept ? start_k : fail_q;
    assign fail_raddr = (rd_k == '0) ? '0 : (rd_k - IW'(1));

    // Pattern byte written as soon as the load is taken
    assign pat_we = ctl.accept && is_load && !full;

    // Failure entry: zero for the first byte, walk result otherwise
    always_comb
    begin
        fail_we    = 1'b0;
        fail_waddr = '0;
        fail_wdata = '0;
        if (ctl.finish && !is_text_reg)
        begin
            fail_we    = 1'b1;
            fail_waddr = len_reg[IW-1:0];
            fail_wdata = k_final[IW-1:0];
        end
        else if (ctl.accept && is_load && (len_reg == '0))
        begin
            fail_we = 1'b1;
        end
    end

    kmp_ram #(
        .WIDTH (KMP_BYTE_W),
        .DEPTH (MAX_PATTERN)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (len_reg[IW-1:0]),
        .wdata (item_byte),
        .raddr (rd_k),
        .rdata (pat_q)
    );

    kmp_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_PATTERN)
    ) u_fail_ram (
        .clk   (clk),
        .we    (fail_we),
        .waddr (fail_waddr),
        .wdata (fail_wdata),
        .raddr (fail_raddr),
        .rdata (fail_q)
    );

    // Status to controller
    assign out_load     = res_valid_reg && (!out_valid_reg || out_ready);
    assign sts.res_free = !res_valid_reg || out_load;
    assign sts.walk_start = (is_load && !full && (len_reg != '0))
                         || (is_text && (len_reg != '0));
    assign sts.walk_done  = hit || (k_reg == '0);

    // State update and result
    always_comb
    begin
        len_next        = len_reg;
        bpl_next        = bpl_reg;
        tml_next        = tml_reg;
        pos_next        = pos_reg;
        res_write       = 1'b0;
        res_found_next  = 1'b0;
        res_start_next  = '0;
        res_status_next = 1'b0;

        if (ctl.accept && !sts.walk_start)
        begin
            // items that finish in the accept cycle
            res_write = 1'b1;
            unique case (item_cmd)
                CMD_CLEAR:
                begin
                    len_next = '0;
                    bpl_next = '0;
                    tml_next = '0;
                    pos_next = '0;
                end
                CMD_LOAD:
                begin
                    if (full)
                    begin
                        res_status_next = 1'b1;
                    end
                    else
                    begin
                        // first pattern byte
                        len_next = LW'(1);
                        bpl_next = '0;
                        tml_next = '0;
                        pos_next = '0;
                    end
                end
                CMD_TEXT:
                begin
                    pos_next = pos_reg + KMP_POS_W'(1);
                end
                default:
                begin
                end
            endcase
        end
        else if (ctl.finish)
        begin
            res_write = 1'b1;
            if (is_text_reg)
            begin
                pos_next = pos_reg + KMP_POS_W'(1);
                if (text_hit)
                begin
                    res_found_next = 1'b1;
                    res_start_next = pos_reg - KMP_POS_W'(len_reg) + KMP_POS_W'(1);
                    tml_next       = bpl_reg;
                end
                else
                begin
                    tml_next = k_final[IW-1:0];
                end
            end
            else
            begin
                bpl_next = k_final[IW-1:0];
                len_next = len_reg + LW'(1);
                tml_next = '0;
                pos_next = '0;
            end
        end
    end

    assign res_valid_next = res_write ? 1'b1 : (out_load ? 1'b0 : res_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            bpl_reg       <= '0;
            tml_reg       <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            bpl_reg       <= bpl_next;
            tml_reg       <= tml_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            is_text_reg <= is_text;
            byte_reg    <= item_byte;
            k_reg       <= start_k;
        end
        else if (ctl.step)
        begin
            k_reg <= fail_q;
        end
        if (res_write)
        begin
            res_found_reg  <= res_found_next;
            res_start_reg  <= res_start_next;
            res_status_reg <= res_status_next;
        end
        if (out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_start_reg  <= res_start_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign match_start = out_start_reg;
    assign status      = out_status_reg;

    // Match progress always stays inside the loaded pattern
    `KMP_ASSERT_IMPL(a_tml_below_len, clk, rst_n,
        len_reg != '0, LW'(tml_reg) < len_reg,
        "text match length reached pattern length")
    `KMP_ASSERT_IMPL(a_bpl_below_len, clk, rst_n,
        len_reg != '0, LW'(bpl_reg) < len_reg,
        "prefix length reached pattern length")
    // Each fallback must move strictly down the table
    `KMP_ASSERT_IMPL(a_step_shrinks, clk, rst_n,
        ctl.step, fail_q < k_reg,
        "failure fallback did not shrink match length")
    // A finishing walk always finds the skid slot empty
    `KMP_ASSERT_IMPL(a_finish_slot_free, clk, rst_n,
        ctl.finish, !res_valid_reg,
        "walk finished into an occupied result slot")
    // A taken item leaves a pending result or a walk behind it
    `KMP_ASSERT_NEXT(a_accept_progress, clk, rst_n,
        ctl.accept, res_valid_reg || ctl.step || ctl.finish,
        "accepted item produced no progress")

endmodule

// ===== rtl/kmp_stream_matcher_core.sv =====
// Channel   Dir  Payload                          Handshake
// item      in   cmd[1:0], data_byte[7:0]         valid/ready
// result    out  found, match_start[31:0], status valid/ready
//
// Clear, ignored loads, the first pattern byte, unused commands and text on an
// empty pattern finish in the accept cycle. Other loads and text bytes fall
// back until a hit or zero; each lookup is one read of the pattern and
// failure RAMs. A finished result passes through the skid and output
// registers to the port; the skid lets an item be taken while the previous
// result waits. Reset clears all match state; RAM contents are not reset.
module kmp_stream_matcher_core import kmp_pkg::*; #(
    parameter int MAX_PATTERN = KMP_MAX_PATTERN
) (
    input  logic         clk,
    input  logic         rst_n,
    kmp_item_if.sink     item,
    kmp_result_if.source result
);

    kmp_ctl_t ctl;
    kmp_sts_t sts;

    // Sequencer
    kmp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    // Tables, match state and result stages
    kmp_dp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_cmd    (item.cmd),
        .item_byte   (item.data_byte),
        .ctl         (ctl),
        .sts         (sts),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .found       (result.found),
        .match_start (result.match_start),
        .status      (result.status)
    );

endmodule
